// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the advertiser tracking table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define AAT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("aat assertion failed");

// Condition in one cycle implies a condition in the next.
`define AAT_ASSERT_NEXT(lbl, pre, post) \
  `AAT_ASSERT(lbl, (pre) |=> (post))

`endif

// ===== rtl/aat_pkg.sv =====
// Types, constants and helpers for the advertiser tracking table.
package aat_pkg;

  localparam int unsigned TableEntriesDef = 64;

  localparam int unsigned AddrW  = 48;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned RssiW  = 8;
  localparam int unsigned VendW  = 16;
  localparam int unsigned WcntW  = 16;
  localparam int unsigned CntW   = 7;
  localparam int unsigned RateW  = 20;
  localparam int unsigned StatW  = 2;
  localparam int unsigned IntvW  = 22;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned NumW   = 42;   // advert delta times 1000
  localparam int unsigned WideW  = 9;    // holds any count up to 256

  localparam logic [TimeW-1:0] StaleRst    = 32'd15000;
  localparam logic [TimeW-1:0] ActiveRst   = 32'd10000;
  localparam logic [TimeW-1:0] MinSpacing  = 32'd1000;
  localparam logic [NumW-1:0]  MsPerS      = 42'd1000;
  localparam logic [37:0]      BusyNext    = 38'd51;    // above 50/s means >= 51
  localparam logic [NumW-1:0]  FloodRate   = 42'd300;
  localparam logic [WideW-1:0] FloodActive = 9'd20;
  localparam logic [NumW-1:0]  HighRate    = 42'd150;
  localparam logic [WideW-1:0] SpikeAdded  = 9'd10;
  localparam logic [RssiW-1:0] RssiFloor   = 8'h81;     // -127
  localparam logic [VendW-1:0] VendorNone  = 16'hffff;
  localparam logic [WcntW-1:0] WcntMax     = 16'hffff;
  localparam logic [RateW-1:0] RateMax     = 20'hfffff;
  localparam logic [CntW-1:0]  CntMax      = 7'd127;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SCAN_EN  = 2'd0,
    REG_INTERVAL = 2'd1,
    REG_STALE    = 2'd2,
    REG_ACTIVE   = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_ADVERT = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_NORMAL = 2'd0,
    STAT_FLOOD  = 2'd1,
    STAT_HIGH   = 2'd2,
    STAT_SPIKE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [TimeW-1:0] seen;
    logic [RssiW-1:0] rssi;
    logic [VendW-1:0] vendor;
    logic [WcntW-1:0] wcnt;
  } entry_t;

  typedef struct packed {
    logic [5:0]       pad;
    logic [StatW-1:0] status;
    logic [CntW-1:0]  busy;
    logic [VendW-1:0] vendor;
    logic [AddrW-1:0] addr;
    logic [RssiW-1:0] rssi;
    logic [TimeW-1:0] overflow;
    logic [TimeW-1:0] total;
    logic [RateW-1:0] rate;
    logic [CntW-1:0]  gone;
    logic [CntW-1:0]  added;
    logic [CntW-1:0]  active;
  } out_t;

  typedef struct packed {
    logic load;
    logic adv_eval;
    logic adv_write;
    logic idx_inc;
    logic tick_init;
    logic tick_eval;
    logic div_start;
    logic div_step;
    logic x_eval;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_en;
    logic tick_due;
    logic idx_last;
    logic div_last;
    logic x_skip;
    logic x_done;
    logic out_free;
  } sts_t;

  function automatic logic [CntW-1:0] sat7(input logic [WideW-1:0] v);
    return (v > WideW'(CntMax)) ? CntMax : v[CntW-1:0];
  endfunction

endpackage

// ===== rtl/aat_ram.sv =====
// Generic single-port-write, registered-read RAM.
module aat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/aat_ctrl.sv =====
// Sequencer for advert search, tick walk, rate divide and set compare.
`include "assert_macros.svh"

module aat_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_tick_i,
  output logic          in_ready_o,
  input  aat_pkg::sts_t sts_i,
  output aat_pkg::cmd_t cmd_o
);
  import aat_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_ARD  = 11'b000_0000_0010,
    S_AEV  = 11'b000_0000_0100,
    S_AWR  = 11'b000_0000_1000,
    S_TCHK = 11'b000_0001_0000,
    S_TRD  = 11'b000_0010_0000,
    S_TEV  = 11'b000_0100_0000,
    S_DIV  = 11'b000_1000_0000,
    S_XRD  = 11'b001_0000_0000,
    S_XEV  = 11'b010_0000_0000,
    S_FIN  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_tick_i) begin
            state_d = S_TCHK;
          end else if (sts_i.scan_en) begin
            state_d = S_ARD;
          end
        end
      end
      S_ARD: state_d = S_AEV;
      S_AEV: begin
        cmd_o.adv_eval = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_AWR;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_ARD;
        end
      end
      S_AWR: begin
        cmd_o.adv_write = 1'b1;
        state_d         = S_IDLE;
      end
      S_TCHK: begin
        if (sts_i.tick_due) begin
          cmd_o.tick_init = 1'b1;
          state_d         = S_TRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_TRD: state_d = S_TEV;
      S_TEV: begin
        cmd_o.tick_eval = 1'b1;
        if (sts_i.idx_last) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_TRD;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = sts_i.x_skip ? S_FIN : S_XRD;
        end
      end
      S_XRD: state_d = S_XEV;
      S_XEV: begin
        cmd_o.x_eval = 1'b1;
        state_d      = sts_i.x_done ? S_FIN : S_XRD;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `AAT_ASSERT(a_write_after_scan, (state_q == S_AWR) |-> $past(state_q == S_AEV))
  `AAT_ASSERT_NEXT(a_div_then_compare, (state_q == S_DIV) && sts_i.div_last,
                   (state_q == S_XRD) || (state_q == S_FIN))
  `AAT_ASSERT(a_finish_only_free, cmd_o.finish |-> sts_i.out_free)

endmodule

// ===== rtl/aat_dp.sv =====
// Datapath: table and list memories, counters, divider and result register.
`include "assert_macros.svh"

module aat_dp #(
  parameter int unsigned TableEntries = aat_pkg::TableEntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aat_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [aat_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_tick_i,
  input  logic [aat_pkg::TimeW-1:0]     in_now_i,
  input  logic [aat_pkg::AddrW-1:0]     in_addr_i,
  input  logic [aat_pkg::RssiW-1:0]     in_rssi_i,
  input  logic [aat_pkg::VendW-1:0]     in_vend_i,
  input  aat_pkg::cmd_t                 cmd_i,
  output aat_pkg::sts_t                 sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output aat_pkg::out_t                 out_data_o
);
  import aat_pkg::*;

  localparam int unsigned IW = $clog2(TableEntries);
  localparam int unsigned CW = $clog2(TableEntries + 1);

  // configuration
  logic             scan_en_q;
  logic [IntvW-1:0] interval_q;
  logic [TimeW-1:0] stale_q, actwin_q;

  // captured word
  logic [TimeW-1:0] now_q;
  logic [AddrW-1:0] addr_q;
  logic [RssiW-1:0] rssi_q;
  logic [VendW-1:0] vend_q;

  logic [TableEntries-1:0] valid_q;
  logic [TimeW-1:0] ad_total_q, drop_total_q, last_tick_q, ad_at_tick_q, elapsed_q;
  logic [37:0]      el51_q;
  logic [IW-1:0]    idx_q, hit_idx_q, free_idx_q, i_q, j_q;
  logic             hit_q, free_q, bank_q;
  logic [WcntW-1:0] hit_wcnt_q;
  logic [CW-1:0]    active_q, busy_q, prev_used_q, inter_q;
  logic [RssiW-1:0] best_rssi_q;
  logic [AddrW-1:0] best_addr_q;
  logic [VendW-1:0] best_vend_q;
  logic [TimeW-1:0] rem_q;
  logic [NumW-1:0]  num_q, quo_q;
  logic [5:0]       div_cnt_q;
  logic             out_valid_q;
  out_t             out_q;

  entry_t        ent_rd, ent_wr;
  logic          ent_we;
  logic [IW-1:0] ent_waddr;
  logic [AddrW-1:0] l0_rd, l1_rd, cur_rd, prev_rd;
  logic          l0_we, l1_we;
  logic [IW-1:0] l0_raddr, l1_raddr;

  logic          ent_v, is_match, is_free, is_active, is_busy;
  logic [25:0]   wprod;
  logic [TimeW-1:0] spacing;
  logic [32:0]   rem_sh;
  logic          div_ge;
  logic          j_last, i_last;
  logic [CW-1:0] added, gone;
  status_e       status;
  out_t          out_d;

  aat_ram #(.Width($bits(entry_t)), .Depth(TableEntries)) u_ent_ram (
    .clk_i, .we_i(ent_we), .waddr_i(ent_waddr), .wdata_i(ent_wr),
    .raddr_i(idx_q), .rdata_o(ent_rd)
  );
  aat_ram #(.Width(AddrW), .Depth(TableEntries)) u_list0_ram (
    .clk_i, .we_i(l0_we), .waddr_i(active_q[IW-1:0]), .wdata_i(ent_rd.addr),
    .raddr_i(l0_raddr), .rdata_o(l0_rd)
  );
  aat_ram #(.Width(AddrW), .Depth(TableEntries)) u_list1_ram (
    .clk_i, .we_i(l1_we), .waddr_i(active_q[IW-1:0]), .wdata_i(ent_rd.addr),
    .raddr_i(l1_raddr), .rdata_o(l1_rd)
  );

  always_comb begin
    ent_v     = valid_q[idx_q];
    is_match  = ent_v && (ent_rd.addr == addr_q);
    is_free   = !ent_v || ((now_q - ent_rd.seen) > stale_q);
    is_active = ent_v && ((now_q - ent_rd.seen) < actwin_q);
    wprod     = 26'(ent_rd.wcnt) * 26'd1000;
    is_busy   = ent_v && (38'(wprod) >= el51_q);
    spacing   = (32'(interval_q) > MinSpacing) ? 32'(interval_q) : MinSpacing;

    // entry write port: advert update or window clear on tick
    ent_we    = 1'b0;
    ent_waddr = idx_q;
    ent_wr    = ent_rd;
    ent_wr.wcnt = '0;
    if (cmd_i.tick_eval) begin
      ent_we = 1'b1;
    end else if (cmd_i.adv_write && (hit_q || free_q)) begin
      ent_we      = 1'b1;
      ent_waddr   = hit_q ? hit_idx_q : free_idx_q;
      ent_wr.addr   = addr_q;
      ent_wr.seen   = now_q;
      ent_wr.rssi   = rssi_q;
      ent_wr.vendor = vend_q;
      ent_wr.wcnt   = hit_q ? ((hit_wcnt_q == WcntMax) ? WcntMax : hit_wcnt_q + 1'b1)
                            : WcntW'(1);
    end

    // bank_q names the bank holding the previous set
    l0_we    = cmd_i.tick_eval && is_active && bank_q;
    l1_we    = cmd_i.tick_eval && is_active && !bank_q;
    l0_raddr = bank_q ? i_q : j_q;
    l1_raddr = bank_q ? j_q : i_q;
    cur_rd   = bank_q ? l0_rd : l1_rd;
    prev_rd  = bank_q ? l1_rd : l0_rd;

    rem_sh = {rem_q, num_q[NumW-1]};
    div_ge = rem_sh >= {1'b0, elapsed_q};

    j_last = (CW'(j_q) + 1'b1) == prev_used_q;
    i_last = (CW'(i_q) + 1'b1) == active_q;

    added = active_q - inter_q;
    gone  = prev_used_q - inter_q;
    if ((quo_q > FloodRate) && (WideW'(active_q) > FloodActive)) begin
      status = STAT_FLOOD;
    end else if (quo_q > HighRate) begin
      status = STAT_HIGH;
    end else if ((prev_used_q != '0) && (WideW'(added) > SpikeAdded)) begin
      status = STAT_SPIKE;
    end else begin
      status = STAT_NORMAL;
    end

    out_d          = '0;
    out_d.active   = sat7(WideW'(active_q));
    out_d.added    = sat7(WideW'(added));
    out_d.gone     = sat7(WideW'(gone));
    out_d.rate     = (|quo_q[NumW-1:RateW]) ? RateMax : quo_q[RateW-1:0];
    out_d.total    = ad_total_q;
    out_d.overflow = drop_total_q;
    out_d.rssi     = best_rssi_q;
    out_d.addr     = best_addr_q;
    out_d.vendor   = best_vend_q;
    out_d.busy     = sat7(WideW'(busy_q));
    out_d.status   = status;

    sts_o.scan_en  = scan_en_q;
    sts_o.tick_due = elapsed_q >= spacing;
    sts_o.idx_last = idx_q == IW'(TableEntries - 1);
    sts_o.div_last = div_cnt_q == 6'(NumW - 1);
    sts_o.x_skip   = (active_q == '0) || (prev_used_q == '0);
    sts_o.x_done   = i_last && j_last;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_en_q    <= 1'b0;
      interval_q   <= '0;
      stale_q      <= StaleRst;
      actwin_q     <= ActiveRst;
      valid_q      <= '0;
      ad_total_q   <= '0;
      drop_total_q <= '0;
      last_tick_q  <= '0;
      ad_at_tick_q <= '0;
      prev_used_q  <= '0;
      bank_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_SCAN_EN:  scan_en_q  <= cfg_data_i[0];
          REG_INTERVAL: interval_q <= cfg_data_i[IntvW-1:0];
          REG_STALE:    stale_q    <= cfg_data_i;
          REG_ACTIVE:   actwin_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load && !in_tick_i && scan_en_q) begin
        ad_total_q <= ad_total_q + 1'b1;
      end
      if (cmd_i.adv_write) begin
        if (hit_q || free_q) begin
          valid_q[ent_waddr] <= 1'b1;
        end else begin
          drop_total_q <= drop_total_q + 1'b1;
        end
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        out_valid_q  <= 1'b1;
        prev_used_q  <= active_q;
        bank_q       <= !bank_q;
        last_tick_q  <= now_q;
        ad_at_tick_q <= ad_total_q;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
      active_q <= '0;
      busy_q   <= '0;
      inter_q  <= '0;
      i_q      <= '0;
      j_q      <= '0;
      div_cnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end
      if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.adv_eval) begin
        if (is_match && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (is_free && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (cmd_i.tick_init) begin
        idx_q    <= '0;
        active_q <= '0;
        busy_q   <= '0;
        inter_q  <= '0;
      end
      if (cmd_i.tick_eval) begin
        if (is_active) active_q <= active_q + 1'b1;
        if (is_busy)   busy_q   <= busy_q + 1'b1;
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
        inter_q   <= '0;
        i_q       <= '0;
        j_q       <= '0;
      end
      if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      if (cmd_i.x_eval) begin
        if (cur_rd == prev_rd) inter_q <= inter_q + 1'b1;
        if (j_last) begin
          j_q <= '0;
          if (!i_last) i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q     <= in_now_i;
      addr_q    <= in_addr_i;
      rssi_q    <= in_rssi_i;
      vend_q    <= in_vend_i;
      elapsed_q <= in_now_i - last_tick_q;
    end
    if (cmd_i.adv_eval) begin
      if (is_match && !hit_q) begin
        hit_idx_q  <= idx_q;
        hit_wcnt_q <= ent_rd.wcnt;
      end
      if (is_free && !free_q) begin
        free_idx_q <= idx_q;
      end
    end
    if (cmd_i.tick_init) begin
      el51_q      <= 38'(elapsed_q) * BusyNext;
      best_rssi_q <= RssiFloor;
      best_addr_q <= '0;
      best_vend_q <= VendorNone;
    end
    if (cmd_i.tick_eval && is_active &&
        ($signed(ent_rd.rssi) > $signed(best_rssi_q))) begin
      best_rssi_q <= ent_rd.rssi;
      best_addr_q <= ent_rd.addr;
      best_vend_q <= ent_rd.vendor;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      num_q <= NumW'(ad_total_q - ad_at_tick_q) * MsPerS;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= div_ge ? TimeW'(rem_sh - {1'b0, elapsed_q}) : rem_sh[TimeW-1:0];
      num_q <= {num_q[NumW-2:0], 1'b0};
      quo_q <= {quo_q[NumW-2:0], div_ge};
    end
    if (cmd_i.finish) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `AAT_ASSERT(a_active_bound, active_q <= CW'(TableEntries))
  `AAT_ASSERT(a_inter_bound, (inter_q <= active_q) && (inter_q <= prev_used_q))
  `AAT_ASSERT_NEXT(a_finish_shows, cmd_i.finish, out_valid_q)

endmodule

// ===== rtl/advertiser_tracking_table.sv =====
// Top level of the advertiser tracking table.
//
//  channel  dir  handshake             payload
//  s_axis   in   tvalid/tready         tuser command, tdata item fields
//  m_axis   out  tvalid/tready         tdata tick summary
//  cfg      in   cfg_we_i              cfg_idx_i, cfg_data_i
//
// One word at a time. Advert: accept, a read and an evaluate per table entry,
// then write-back. Tick: accept, due check, table walk, 42-step bit-serial rate
// divide, matching A current against P previous addresses (skipped if either
// set is empty), result load. An early tick ends at its due check, a disabled
// advert at accept. Reset clears valid flags and counters at once. A tick
// stalls at its result load while the previous result still waits.
module advertiser_tracking_table #(
  parameter int unsigned TableEntries = aat_pkg::TableEntriesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // now_ms[31:0], address[79:32], rssi[87:80], vendor_id[103:88]
  input  logic [103:0]                s_axis_tdata,
  // command
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // active_count, added_count, gone_count, advert_rate, advert_total,
  // overflow_total, strongest_rssi, strongest_address, strongest_vendor,
  // busy_count, status, zero pad
  output logic [191:0]                m_axis_tdata,
  input  logic                        cfg_we_i,
  input  logic [aat_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [aat_pkg::CfgW-1:0]    cfg_data_i
);
  import aat_pkg::*;

  cmd_t cmd;
  sts_t sts;
  out_t out_word;
  logic in_tick;

  assign in_tick = s_axis_tuser == CMD_TICK;

  aat_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_tick_i(in_tick), .in_ready_o(s_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  aat_dp #(.TableEntries(TableEntries)) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_tick_i(in_tick),
    .in_now_i(s_axis_tdata[31:0]),
    .in_addr_i(s_axis_tdata[79:32]),
    .in_rssi_i(s_axis_tdata[87:80]),
    .in_vend_i(s_axis_tdata[103:88]),
    .cmd_i(cmd), .sts_o(sts),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid), .out_data_o(out_word)
  );

  assign m_axis_tdata = out_word;

endmodule
